[rtl/dvrt_pkg.sv]
// dvrt_pkg: shared types and constants of the distance-vector route table unit
// no dependencies
package dvrt_pkg;

  localparam int unsigned NODES        = 16;
  localparam int unsigned NODE_W       = 4;
  localparam int unsigned HOP_W        = 5;
  localparam int unsigned COST_W       = 8;
  localparam int unsigned LIFE_W       = 2;
  localparam int unsigned QUEUE_DEPTH  = 2;

  localparam logic [COST_W-1:0] INF_COST     = 8'd255;
  localparam logic [LIFE_W-1:0] MAX_LIFETIME = 2'd3;
  localparam logic [HOP_W-1:0]  UNDEFINED    = 5'd16;

  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_SET     = 3'd1,
    CMD_COST    = 3'd2,
    CMD_HEADER  = 3'd3,
    CMD_ROW     = 3'd4,
    CMD_LOOKUP  = 3'd5,
    CMD_BAD6    = 3'd6,
    CMD_BAD7    = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_ACK     = 3'd0,
    KIND_ROW     = 3'd1,
    KIND_DELIVER = 3'd2,
    KIND_FORWARD = 3'd3,
    KIND_DROP    = 3'd4
  } kind_e;

  // classified command handed from front to back
  typedef struct packed {
    cmd_e              cmd;
    logic [NODE_W-1:0] nbr;
    logic [NODE_W-1:0] dest;
    logic [HOP_W-1:0]  rnh;
    logic [COST_W-1:0] cost;
    logic              skip;
  } op_t;

  typedef struct packed {
    kind_e             kind;
    logic [NODE_W-1:0] dest;
    logic [HOP_W-1:0]  next_hop;
    logic [COST_W-1:0] cost;
    logic [NODES-1:0]  send_mask;
    logic              last;
  } res_t;

endpackage

[rtl/dvrt_front.sv]
// dvrt_front: accepts command beats, classifies them, and queues them for the back end
// depends on dvrt_pkg
module dvrt_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [2:0]            cmd_i,
  input  logic [3:0]            node_a_i,
  input  logic [3:0]            node_b_i,
  input  logic [3:0]            dest_i,
  input  logic [4:0]            row_next_hop_i,
  input  logic [7:0]            cost_i,
  input  logic [3:0]            self_node_i,
  input  logic                  push_i,
  output logic                  full_o,
  output logic                  op_valid_o,
  input  logic                  op_take_i,
  output dvrt_pkg::op_t         op_o
);
  import dvrt_pkg::*;

  op_t              mem_q [QUEUE_DEPTH];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;
  op_t              op_in;
  logic [3:0]       pick;
  logic             do_push, do_pop;

  assign pick = (node_a_i == self_node_i) ? node_b_i : node_a_i;

  always_comb begin
    op_in      = '0;
    op_in.cmd  = cmd_e'(cmd_i);
    op_in.dest = dest_i;
    op_in.rnh  = row_next_hop_i;
    op_in.cost = cost_i;
    unique case (cmd_e'(cmd_i))
      CMD_SET, CMD_COST: begin
        op_in.nbr  = pick;
        op_in.skip = (pick == self_node_i);
      end
      CMD_HEADER: begin
        op_in.nbr  = node_a_i;
        op_in.skip = (node_a_i == self_node_i);
      end
      CMD_ROW: begin
        op_in.nbr  = node_a_i;
        op_in.skip = (node_a_i == self_node_i) || (dest_i == self_node_i)
                     || (row_next_hop_i == {1'b0, self_node_i});
      end
      default: begin
        op_in.nbr  = node_a_i;
      end
    endcase
  end

  assign full_o     = (cnt_q == 2'(QUEUE_DEPTH));
  assign op_valid_o = (cnt_q != 2'd0);
  assign op_o       = mem_q[rd_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = op_take_i && op_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= op_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(QUEUE_DEPTH)) else $error("op queue overflow");
  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !do_pop |=> cnt_q == 2'(QUEUE_DEPTH)) else $error("full queue changed");
  a_empty_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> !op_valid_o) else $error("valid on empty queue");

endmodule

[rtl/dvrt_back.sv]
// dvrt_back: executes queued commands on the route and link tables, emits result beats
// depends on dvrt_pkg
module dvrt_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [3:0]            self_node_i,
  input  logic                  op_valid_i,
  output logic                  op_take_o,
  input  dvrt_pkg::op_t         op_i,
  output logic                  empty_o,
  input  logic                  pop_i,
  output dvrt_pkg::res_t        res_o
);
  import dvrt_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ROW  = 2'd1;
  localparam logic [1:0] ST_TICK = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [COST_W-1:0] rcost_q [NODES];
  logic [HOP_W-1:0]  rnext_q [NODES];
  logic [COST_W-1:0] lcost_q [NODES];
  logic [LIFE_W-1:0] life_q  [NODES];
  logic [NODES-1:0]  nbr_q;

  logic [1:0]        st_q;
  logic [NODE_W-1:0] idx_q;
  op_t               op_q;
  logic [COST_W-1:0] cand_q;
  logic [HOP_W-1:0]  via_q;
  res_t              out_q;
  logic              out_v_q;

  logic              out_free;
  logic              emit_go;
  logic [NODES-1:0]  mask;
  logic [COST_W-1:0] rc, lc, base;
  logic [COST_W:0]   sum;
  logic [NODE_W-1:0] n;
  res_t              r;

  assign out_free  = !out_v_q || pop_i;
  assign emit_go   = ((st_q == ST_EMIT) || (st_q == ST_TICK)) && out_free;
  assign empty_o   = !out_v_q;
  assign res_o     = out_q;
  assign op_take_o = (st_q == ST_IDLE) && op_valid_i;
  assign n         = op_i.nbr;

  always_comb begin
    for (int i = 0; i < NODES; i++) mask[i] = nbr_q[i] && (lcost_q[i] != INF_COST);
  end

  // relaxation base from the neighbour's entries, registered before the compare
  assign rc   = rcost_q[op_i.nbr];
  assign lc   = lcost_q[op_i.nbr];
  assign base = (rc < lc) ? rc : lc;
  assign sum  = {1'b0, base} + {1'b0, op_i.cost};

  always_comb begin
    r      = '0;
    r.last = 1'b1;
    r.dest = op_q.dest;
    if (op_q.cmd == CMD_LOOKUP) begin
      if (op_q.dest == self_node_i) begin
        r.kind     = KIND_DELIVER;
        r.next_hop = {1'b0, self_node_i};
      end else begin
        r.next_hop = rnext_q[op_q.dest];
        r.cost     = rcost_q[op_q.dest];
        r.kind     = (r.next_hop != UNDEFINED || r.cost != INF_COST) ? KIND_FORWARD
                                                                     : KIND_DROP;
      end
    end else begin
      r.dest = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_take_o) begin
      op_q   <= op_i;
      via_q  <= (rc < lc) ? rnext_q[op_i.nbr] : {1'b0, op_i.nbr};
      cand_q <= (sum >= {1'b0, INF_COST}) ? INF_COST : sum[COST_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      idx_q   <= '0;
      out_q   <= '0;
      out_v_q <= 1'b0;
      nbr_q   <= '0;
      for (int i = 0; i < NODES; i++) begin
        rcost_q[i] <= INF_COST;
        rnext_q[i] <= UNDEFINED;
        lcost_q[i] <= INF_COST;
        life_q[i]  <= '0;
      end
    end else begin
      if (emit_go) out_v_q <= 1'b1;
      else if (pop_i && out_v_q) out_v_q <= 1'b0;
      unique case (st_q)
        ST_IDLE: begin
          if (op_valid_i) begin
            unique case (op_i.cmd)
              CMD_TICK: begin
                idx_q <= '0;
                st_q  <= ST_TICK;
              end
              CMD_SET: begin
                if (!op_i.skip) begin
                  nbr_q[n]   <= 1'b1;
                  lcost_q[n] <= op_i.cost;
                  rnext_q[n] <= {1'b0, n};
                  rcost_q[n] <= op_i.cost;
                end
                st_q <= ST_EMIT;
              end
              CMD_COST: begin
                if (!op_i.skip) begin
                  if (life_q[n] != '0) begin
                    rnext_q[n] <= {1'b0, n};
                    rcost_q[n] <= op_i.cost;
                  end
                  lcost_q[n] <= op_i.cost;
                  nbr_q[n]   <= 1'b1;
                end
                idx_q <= '0;
                st_q  <= ST_TICK;
              end
              CMD_HEADER: begin
                if (!op_i.skip) begin
                  if (life_q[n] == '0) begin
                    rnext_q[n] <= {1'b0, n};
                    rcost_q[n] <= lcost_q[n];
                  end
                  life_q[n] <= MAX_LIFETIME;
                  nbr_q[n]  <= 1'b1;
                end
                st_q <= ST_EMIT;
              end
              CMD_ROW: st_q <= ST_ROW;
              CMD_LOOKUP: st_q <= ST_EMIT;
              default: st_q <= ST_IDLE;
            endcase
          end
        end
        ST_ROW: begin
          // read-modify-write of the destination entry
          if (!op_q.skip && ((rcost_q[op_q.dest] > cand_q)
              || (rnext_q[op_q.dest] == {1'b0, op_q.nbr}))) begin
            rcost_q[op_q.dest] <= cand_q;
            rnext_q[op_q.dest] <= (cand_q == INF_COST) ? UNDEFINED : via_q;
          end
          st_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_q <= r;
            st_q  <= ST_IDLE;
          end
        end
        ST_TICK: begin
          // one table row a cycle while the result slot is free; on a tick, ageing applied on the row in flight
          if (out_free) begin
            logic [LIFE_W-1:0] nl;
            logic              expire;
            nl     = life_q[idx_q];
            expire = 1'b0;
            out_q.kind      <= KIND_ROW;
            out_q.dest      <= idx_q;
            out_q.send_mask <= mask;
            out_q.last      <= (idx_q == NODE_W'(NODES - 1));
            if (op_q.cmd == CMD_TICK && nbr_q[idx_q]) begin
              if (nl != '0) nl = nl - 1'b1;
              life_q[idx_q] <= nl;
              expire = (nl == '0) && (rnext_q[idx_q] == {1'b0, idx_q});
            end
            if (expire) begin
              rnext_q[idx_q] <= UNDEFINED;
              rcost_q[idx_q] <= INF_COST;
            end
            if (idx_q == self_node_i) begin
              out_q.next_hop <= {1'b0, self_node_i};
              out_q.cost     <= '0;
            end else if (expire) begin
              out_q.next_hop <= UNDEFINED;
              out_q.cost     <= INF_COST;
            end else begin
              out_q.next_hop <= rnext_q[idx_q];
              out_q.cost     <= rcost_q[idx_q];
            end
            idx_q   <= idx_q + 1'b1;
            if (idx_q == NODE_W'(NODES - 1)) st_q <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_take_o |-> st_q == ST_IDLE) else $error("op taken while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !pop_i |=> out_v_q && $stable(out_q)) else $error("result lost");
  a_row_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_ROW |=> st_q == ST_EMIT) else $error("row update stuck");

endmodule

[rtl/distance_vector_route_table_unit.sv]
// distance_vector_route_table_unit: top level of the route table engine
// depends on dvrt_pkg, dvrt_front, dvrt_back
//
//  channel  | handshake        | beat
//  ---------+------------------+----------------------------------------------
//  command  | push_i / full_o  | cmd, node_a, node_b, dest, row_next_hop, cost
//  result   | pop_i / empty_o  | kind, out_dest, out_next_hop, out_cost, mask, last
//  config   | cfg_valid_i/rdy  | self_node
//
// ack and lookup commands pass idle then emit; table_row adds a row state between (read, then write)
// tick and a link cost change stream 16 table rows, one per cycle while the result slot is free
// unknown commands give no result
// the back end sequencer is the limit: it owns the single table update path
// a two-entry command queue lets push proceed while results wait on pop
// reset clears every table at once; no clearing pass
module distance_vector_route_table_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  cmd_i,
  input  logic [3:0]  node_a_i,
  input  logic [3:0]  node_b_i,
  input  logic [3:0]  dest_i,
  input  logic [4:0]  row_next_hop_i,
  input  logic [7:0]  cost_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  kind_o,
  output logic [3:0]  out_dest_o,
  output logic [4:0]  out_next_hop_o,
  output logic [7:0]  out_cost_o,
  output logic [15:0] send_mask_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_data_i
);
  import dvrt_pkg::*;

  logic [3:0] self_q;
  logic       op_valid, op_take;
  op_t        op;
  res_t       res;

  // self_node register, always ready
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) self_q <= '0;
    else if (cfg_valid_i) self_q <= cfg_data_i;
  end

  dvrt_front u_front (
    .clk_i, .rst_ni, .cmd_i, .node_a_i, .node_b_i, .dest_i, .row_next_hop_i, .cost_i,
    .self_node_i(self_q), .push_i(push), .full_o(full),
    .op_valid_o(op_valid), .op_take_i(op_take), .op_o(op)
  );

  dvrt_back u_back (
    .clk_i, .rst_ni, .self_node_i(self_q),
    .op_valid_i(op_valid), .op_take_o(op_take), .op_i(op),
    .empty_o(empty), .pop_i(pop), .res_o(res)
  );

  assign kind_o         = res.kind;
  assign out_dest_o     = res.dest;
  assign out_next_hop_o = res.next_hop;
  assign out_cost_o     = res.cost;
  assign send_mask_o    = res.send_mask;
  assign last_o         = res.last;

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// testbench: self-checking bench for distance_vector_route_table_unit
// depends on dvrt_pkg and the rtl top level; directed table then random commands
module testbench;
  import dvrt_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int RANDOM_ITEMS   = 250;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [2:0]  cmd_i = '0;
  logic [3:0]  node_a_i = '0;
  logic [3:0]  node_b_i = '0;
  logic [3:0]  dest_i = '0;
  logic [4:0]  row_next_hop_i = '0;
  logic [7:0]  cost_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  kind_o;
  logic [3:0]  out_dest_o;
  logic [4:0]  out_next_hop_o;
  logic [7:0]  out_cost_o;
  logic [15:0] send_mask_o;
  logic        last_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [3:0]  cfg_data_i = '0;

  always #2 clk_i = ~clk_i;

  distance_vector_route_table_unit dut (.*);

  // one command beat
  typedef struct packed {
    cmd_e              cmd;
    logic [3:0]        a;
    logic [3:0]        b;
    logic [3:0]        dest;
    logic [HOP_W-1:0]  rnh;
    logic [COST_W-1:0] cost;
  } route_cmd_t;

  // directed row: optional typed-in single result
  typedef struct packed {
    route_cmd_t c;
    logic       fixed;
    res_t       want;
  } route_vec_t;

  // predictor state, own copy of the table
  logic [COST_W-1:0] tbl_cost [NODES];
  logic [HOP_W-1:0]  tbl_next [NODES];
  logic [COST_W-1:0] lnk_cost [NODES];
  logic [LIFE_W-1:0] lnk_life [NODES];
  logic              nbr_flag [NODES];
  logic [3:0]        my_node;

  res_t expected_results [$];
  int   errors = 0;
  int   results_seen = 0;
  int   cmds_sent = 0;
  int   idle_cnt = 0;
  bit   quiet_tail = 0;     // no idling in the last part
  bit   hold_off = 0;       // long receiver stall request
  bit   sender_done = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %0s: got %0d want %0d (result %0d)", what, got, want, results_seen);
    errors++;
  endtask

  function automatic res_t mk(kind_e k, logic [3:0] d, logic [4:0] nh, logic [7:0] c,
                              logic [15:0] m, logic l);
    res_t r;
    r.kind = k; r.dest = d; r.next_hop = nh; r.cost = c; r.send_mask = m; r.last = l;
    return r;
  endfunction

  function automatic void reset_routes();
    for (int i = 0; i < NODES; i++) begin
      tbl_cost[i] = INF_COST; tbl_next[i] = UNDEFINED;
      lnk_cost[i] = INF_COST; lnk_life[i] = '0; nbr_flag[i] = 1'b0;
    end
    my_node = '0;
  endfunction

  function automatic void queue_table_rows();
    logic [15:0] m;
    m = '0;
    for (int i = 0; i < NODES; i++)
      if (nbr_flag[i] && lnk_cost[i] != INF_COST) m[i] = 1'b1;
    for (int i = 0; i < NODES; i++)
      if (i == my_node)
        expected_results.push_back(mk(KIND_ROW, 4'(i), {1'b0, my_node}, '0, m,
                                      i == NODES-1));
      else
        expected_results.push_back(mk(KIND_ROW, 4'(i), tbl_next[i], tbl_cost[i], m,
                                      i == NODES-1));
  endfunction

  // route table update for one accepted command
  function automatic void predict_route_update(route_cmd_t c);
    logic [3:0] n;
    logic [COST_W-1:0] rc, lc, base, res;
    logic [HOP_W-1:0] via;
    logic [8:0] sum;
    n = (c.a == my_node) ? c.b : c.a;
    case (c.cmd)
      CMD_TICK: begin
        for (int i = 0; i < NODES; i++) if (nbr_flag[i]) begin
          if (lnk_life[i] != 0) lnk_life[i]--;
          if (lnk_life[i] == 0 && tbl_next[i] == i) begin
            tbl_next[i] = UNDEFINED; tbl_cost[i] = INF_COST;
          end
        end
        queue_table_rows();
      end
      CMD_SET: begin
        if (n != my_node) begin
          nbr_flag[n] = 1'b1; lnk_cost[n] = c.cost; tbl_next[n] = n; tbl_cost[n] = c.cost;
        end
        expected_results.push_back(mk(KIND_ACK, 0, 0, 0, 0, 1));
      end
      CMD_COST: begin
        if (n != my_node) begin
          if (lnk_life[n] != 0) begin tbl_next[n] = n; tbl_cost[n] = c.cost; end
          lnk_cost[n] = c.cost; nbr_flag[n] = 1'b1;
        end
        queue_table_rows();
      end
      CMD_HEADER: begin
        if (c.a != my_node) begin
          if (lnk_life[c.a] == 0) begin tbl_next[c.a] = c.a; tbl_cost[c.a] = lnk_cost[c.a]; end
          lnk_life[c.a] = MAX_LIFETIME; nbr_flag[c.a] = 1'b1;
        end
        expected_results.push_back(mk(KIND_ACK, 0, 0, 0, 0, 1));
      end
      CMD_ROW: begin
        if (c.a != my_node && c.dest != my_node && c.rnh != {1'b0, my_node}) begin
          rc = tbl_cost[c.a]; lc = lnk_cost[c.a];
          via = (rc < lc) ? tbl_next[c.a] : {1'b0, c.a};
          base = (rc < lc) ? rc : lc;
          sum = base + c.cost;
          res = (sum >= INF_COST) ? INF_COST : sum[7:0];
          if (tbl_cost[c.dest] > res || tbl_next[c.dest] == c.a) begin
            tbl_cost[c.dest] = res;
            tbl_next[c.dest] = (res == INF_COST) ? UNDEFINED : via;
          end
        end
        expected_results.push_back(mk(KIND_ACK, 0, 0, 0, 0, 1));
      end
      CMD_LOOKUP: begin
        if (c.dest == my_node)
          expected_results.push_back(mk(KIND_DELIVER, c.dest, {1'b0, my_node}, 0, 0, 1));
        else if (tbl_next[c.dest] != UNDEFINED || tbl_cost[c.dest] != INF_COST)
          expected_results.push_back(mk(KIND_FORWARD, c.dest, tbl_next[c.dest],
                                        tbl_cost[c.dest], 0, 1));
        else
          expected_results.push_back(mk(KIND_DROP, c.dest, tbl_next[c.dest],
                                        tbl_cost[c.dest], 0, 1));
      end
      default: ;  // unknown command: nothing
    endcase
  endfunction

  // ---------------- command side ----------------
  task automatic send_cmd(route_cmd_t c, bit allow_gap);
    int gap;
    if (allow_gap && !quiet_tail && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    cmd_i <= c.cmd; node_a_i <= c.a; node_b_i <= c.b; dest_i <= c.dest;
    row_next_hop_i <= c.rnh; cost_i <= c.cost;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    // beat taken at this edge
    predict_route_update(c);
    cmds_sent++;
  endtask

  task automatic stop_push();
    push <= 1'b0;
  endtask

  task automatic wait_drained();
    stop_push();
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_self(logic [3:0] v);
    cfg_valid_i <= 1'b1; cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    my_node = v;
  endtask

  function automatic route_cmd_t rc_of(cmd_e k, int a, int b, int d, int h, int c);
    route_cmd_t r;
    r.cmd = k; r.a = 4'(a); r.b = 4'(b); r.dest = 4'(d); r.rnh = 5'(h); r.cost = 8'(c);
    return r;
  endfunction

  // well-formed traffic mostly: headers, rows, lookups, occasional ticks
  function automatic route_cmd_t random_cmd();
    route_cmd_t r;
    int p;
    r.a = 4'($urandom); r.b = 4'($urandom); r.dest = 4'($urandom);
    r.rnh = ($urandom_range(0, 7) == 0) ? UNDEFINED : 5'($urandom_range(0, 31));
    p = $urandom_range(0, 9);
    r.cost = (p == 0) ? 8'hFF : (p == 1) ? 8'($urandom) : 8'($urandom_range(0, 20));
    p = $urandom_range(0, 99);
    if (p < 30) r.cmd = CMD_ROW;
    else if (p < 50) r.cmd = CMD_LOOKUP;
    else if (p < 62) r.cmd = CMD_HEADER;
    else if (p < 74) r.cmd = CMD_SET;
    else if (p < 84) r.cmd = CMD_TICK;
    else if (p < 92) r.cmd = CMD_COST;
    else r.cmd = cmd_e'($urandom_range(6, 7));
    return r;
  endfunction

  route_vec_t directed [$];

  initial begin
    route_cmd_t c;
    reset_routes();
    // typed-in rows: after reset, self lookup, range extremes, unknown command
    directed.push_back('{rc_of(CMD_LOOKUP, 0, 0, 0, 0, 0), 1,
                         mk(KIND_DELIVER, 0, 0, 0, 0, 1)});
    directed.push_back('{rc_of(CMD_LOOKUP, 15, 15, 15, 31, 255), 1,
                         mk(KIND_DROP, 15, UNDEFINED, INF_COST, 0, 1)});
    directed.push_back('{rc_of(CMD_BAD6, 15, 15, 15, 31, 255), 0, '0});
    directed.push_back('{rc_of(CMD_BAD7, 0, 0, 0, 0, 0), 0, '0});
    directed.push_back('{rc_of(CMD_SET, 0, 0, 0, 0, 5), 1, mk(KIND_ACK, 0, 0, 0, 0, 1)});
    directed.push_back('{rc_of(CMD_SET, 1, 0, 0, 0, 0), 0, '0});
    directed.push_back('{rc_of(CMD_SET, 0, 15, 0, 0, 255), 0, '0});
    directed.push_back('{rc_of(CMD_SET, 2, 0, 0, 0, 3), 0, '0});
    directed.push_back('{rc_of(CMD_TICK, 0, 0, 0, 0, 0), 0, '0});
    directed.push_back('{rc_of(CMD_HEADER, 2, 0, 0, 0, 0), 0, '0});
    directed.push_back('{rc_of(CMD_HEADER, 0, 0, 0, 0, 0), 1, mk(KIND_ACK, 0, 0, 0, 0, 1)});
    directed.push_back('{rc_of(CMD_ROW, 2, 0, 9, 16, 4), 0, '0});   // relax via neighbor
    directed.push_back('{rc_of(CMD_ROW, 2, 0, 9, 16, 255), 0, '0}); // forced to infinity
    directed.push_back('{rc_of(CMD_ROW, 2, 0, 0, 16, 1), 0, '0});   // dest is self
    directed.push_back('{rc_of(CMD_ROW, 2, 0, 7, 0, 1), 0, '0});    // next hop is self
    directed.push_back('{rc_of(CMD_ROW, 1, 0, 7, 31, 254), 0, '0}); // large cost, stays just below infinity
    directed.push_back('{rc_of(CMD_COST, 2, 0, 0, 0, 8), 0, '0});
    directed.push_back('{rc_of(CMD_COST, 0, 0, 0, 0, 8), 0, '0});   // self: still emits
    directed.push_back('{rc_of(CMD_COST, 0, 14, 0, 0, 6), 0, '0});  // lifetime zero
    directed.push_back('{rc_of(CMD_TICK, 0, 0, 0, 0, 0), 0, '0});
    directed.push_back('{rc_of(CMD_TICK, 0, 0, 0, 0, 0), 0, '0});
    directed.push_back('{rc_of(CMD_TICK, 0, 0, 0, 0, 0), 0, '0});  // neighbor expires
    directed.push_back('{rc_of(CMD_LOOKUP, 0, 0, 2, 0, 0), 0, '0});
    directed.push_back('{rc_of(CMD_LOOKUP, 0, 0, 7, 0, 0), 0, '0});

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      if (directed[i].fixed) begin
        // typed-in result stands in for the prediction
        expected_results.push_back(directed[i].want);
        send_cmd(directed[i].c, 1);
        void'(expected_results.pop_back());
      end else
        send_cmd(directed[i].c, 1);
    end
    wait_drained();

    // several self_node settings, extremes included
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: write_self(4'd15);
        1: write_self(4'd0);
        2: write_self(4'($urandom));
        3: write_self(4'd7);
        default: write_self(4'd15);
      endcase
      for (int k = 0; k < RANDOM_ITEMS / 5; k++) begin
        if (phase == 4 && k > RANDOM_ITEMS / 10) quiet_tail = 1;
        if (phase == 1 && k == 10) begin
          hold_off = 1;     // receiver stalls, we keep offering
        end
        c = random_cmd();
        send_cmd(c, 1);
      end
      if (phase == 2) begin
        // sender pauses until everything is back, then carries on
        stop_push();
        @(posedge clk_i);
        while (expected_results.size() != 0) @(posedge clk_i);
      end
      wait_drained();
    end
    sender_done = 1;
  end

  // ---------------- result side ----------------
  initial begin
    int gap;
    int stall;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        pop <= 1'b0;
        stall = 0;
        while (stall < 200) begin
          @(posedge clk_i);
          stall++;
        end
        hold_off = 0;
      end
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 5);
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
    end
  end

  // compare each popped result with the oldest expectation
  always @(posedge clk_i) begin
    res_t w;
    if (rst_ni && pop && !empty) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result kind", kind_o, -1);
      end else begin
        w = expected_results.pop_front();
        if (kind_o !== w.kind) report_mismatch("kind", kind_o, w.kind);
        if (out_dest_o !== w.dest) report_mismatch("out_dest", out_dest_o, w.dest);
        if (out_next_hop_o !== w.next_hop)
          report_mismatch("out_next_hop", out_next_hop_o, w.next_hop);
        if (out_cost_o !== w.cost) report_mismatch("out_cost", out_cost_o, w.cost);
        if (send_mask_o !== w.send_mask)
          report_mismatch("send_mask", send_mask_o, w.send_mask);
        if (last_o !== w.last) report_mismatch("last", last_o, w.last);
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o) || sender_done)
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", idle_cnt);
      $display("FAIL distance_vector_route_table_unit");
      $finish;
    end
  end

  // end of run
  initial begin
    wait (sender_done);
    $display("covered %0d commands and %0d results over five self_node settings",
             cmds_sent, results_seen);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("PASS distance_vector_route_table_unit");
    end else begin
      $display("%0d mismatches, %0d results outstanding", errors, expected_results.size());
      $display("FAIL distance_vector_route_table_unit");
    end
    $finish;
  end

endmodule
